/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the tile box finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define TABF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
// Checks that a condition never holds outside reset.
`define TABF_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("forbidden condition");
`else
`define TABF_ASSERT(lbl, clk, rstn, prop)
`define TABF_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* hw/rtl/tabf_pkg.sv */
// Shared types and constants of the tile alpha bounding-box finder.
`default_nettype none
package tabf_pkg;

  // Field widths.
  localparam int COORD_BITS    = 12;
  localparam int DIM_BITS      = 13;
  localparam int CNT_BITS      = 5;
  localparam int ALPHA_BITS    = 8;
  localparam int INDEX_BITS    = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int MAX_SLOT_BITS = 6;
  localparam int QUEUE_DEPTH   = 4;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_TILES_ACROSS = 16;
  localparam int DEF_MAX_TILES_DOWN   = 16;

  // Largest image dimension.
  localparam logic [DIM_BITS-1:0] DIM_LIMIT = DIM_BITS'(1 << COORD_BITS);

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TILE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TILE_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TILES_ACROSS = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_TILES_DOWN   = 3'd5;

  // Register reset values.
  localparam logic [DIM_BITS-1:0] RST_IMAGE_WIDTH  = 13'd96;
  localparam logic [DIM_BITS-1:0] RST_IMAGE_HEIGHT = 13'd160;
  localparam logic [DIM_BITS-1:0] RST_TILE_WIDTH   = 13'd32;
  localparam logic [DIM_BITS-1:0] RST_TILE_HEIGHT  = 13'd32;
  localparam logic [CNT_BITS-1:0] RST_TILES_ACROSS = 5'd3;
  localparam logic [CNT_BITS-1:0] RST_TILES_DOWN   = 5'd5;

  // Front control states.
  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_START = 3'b010,
    ST_DIV   = 3'b100
  } front_state_e;

  // One classified in-grid pixel, passed from front to back.
  typedef struct packed {
    logic [MAX_SLOT_BITS-1:0] slot;
    logic                     painted;
    logic                     first;
    logic                     last_col;
    logic                     last_row;
    logic [COORD_BITS-1:0]    col;
    logic [COORD_BITS-1:0]    row;
    logic                     emit;
    logic [INDEX_BITS-1:0]    tile_index;
    logic                     last_tile;
  } op_t;

  typedef struct packed {
    logic busy;
    logic push;
  } front_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic pop;
    logic emit;
  } back_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/tabf_div.sv */
// Restoring divider, one quotient bit per cycle, for re-deriving tile position.
`default_nettype none
module tabf_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [tabf_pkg::COORD_BITS-1:0]     dividend_i,
  input  wire logic [tabf_pkg::DIM_BITS-1:0]       divisor_i,
  output      logic                                busy_o,
  output      logic [tabf_pkg::COORD_BITS-1:0]     quot_o,
  output      logic [tabf_pkg::COORD_BITS-1:0]     rem_o
);

  localparam int CW = tabf_pkg::COORD_BITS;
  localparam int DW = tabf_pkg::DIM_BITS;
  localparam int NW = $clog2(CW + 1);

  logic [DW-1:0] rem_q, rem_d;
  logic [CW-1:0] quo_q, quo_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [DW:0]   trial;
  logic          fits;

  // One shift-and-subtract step.
  always_comb begin
    trial = {rem_q, quo_q[CW-1]};
    fits  = trial >= {1'b0, divisor_i};
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = NW'(CW);
    end else if (cnt_q != '0) begin
      rem_d = fits ? DW'(trial - {1'b0, divisor_i}) : trial[DW-1:0];
      quo_d = {quo_q[CW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quo_q;
  assign rem_o  = rem_q[CW-1:0];

endmodule
`default_nettype wire

/* hw/rtl/tabf_front.sv */
// Front part: configuration, raster position tracking and pixel classification.
`default_nettype none
module tabf_front #(
  parameter int MAX_TILES_ACROSS = tabf_pkg::DEF_MAX_TILES_ACROSS,
  parameter int MAX_TILES_DOWN   = tabf_pkg::DEF_MAX_TILES_DOWN
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [tabf_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [tabf_pkg::DIM_BITS-1:0]        cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output      logic                                 in_ready_o,
  input  wire logic [tabf_pkg::ALPHA_BITS-1:0]      in_alpha_i,
  input  wire logic                                 queue_full_i,
  output      tabf_pkg::op_t                        op_o,
  output      tabf_pkg::front_stat_t                stat_o
);

  localparam int CW = tabf_pkg::COORD_BITS;
  localparam int DW = tabf_pkg::DIM_BITS;
  localparam int NB = tabf_pkg::CNT_BITS;
  localparam int EB = 7;
  localparam logic [EB-1:0] MAX_ACROSS_C = EB'(MAX_TILES_ACROSS);
  localparam logic [EB-1:0] MAX_DOWN_C   = EB'(MAX_TILES_DOWN);

  // Configuration registers.
  logic [DW-1:0] img_w_q, img_h_q, tile_w_q, tile_h_q;
  logic [NB-1:0] across_q, down_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= tabf_pkg::RST_IMAGE_WIDTH;
      img_h_q  <= tabf_pkg::RST_IMAGE_HEIGHT;
      tile_w_q <= tabf_pkg::RST_TILE_WIDTH;
      tile_h_q <= tabf_pkg::RST_TILE_HEIGHT;
      across_q <= tabf_pkg::RST_TILES_ACROSS;
      down_q   <= tabf_pkg::RST_TILES_DOWN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tabf_pkg::REG_IMAGE_WIDTH:  img_w_q  <= cfg_wdata_i;
        tabf_pkg::REG_IMAGE_HEIGHT: img_h_q  <= cfg_wdata_i;
        tabf_pkg::REG_TILE_WIDTH:   tile_w_q <= cfg_wdata_i;
        tabf_pkg::REG_TILE_HEIGHT:  tile_h_q <= cfg_wdata_i;
        tabf_pkg::REG_TILES_ACROSS: across_q <= cfg_wdata_i[NB-1:0];
        tabf_pkg::REG_TILES_DOWN:   down_q   <= cfg_wdata_i[NB-1:0];
        default: ;
      endcase
    end
  end

  // Effective image size and tile counts.
  logic [DW-1:0] w_eff, h_eff;
  logic [EB-1:0] across_eff, down_eff;

  always_comb begin
    w_eff = (img_w_q == '0) ? DW'(1) :
            (img_w_q > tabf_pkg::DIM_LIMIT) ? tabf_pkg::DIM_LIMIT : img_w_q;
    h_eff = (img_h_q == '0) ? DW'(1) :
            (img_h_q > tabf_pkg::DIM_LIMIT) ? tabf_pkg::DIM_LIMIT : img_h_q;
    across_eff = ({2'b00, across_q} > MAX_ACROSS_C) ? MAX_ACROSS_C : {2'b00, across_q};
    down_eff   = ({2'b00, down_q} > MAX_DOWN_C) ? MAX_DOWN_C : {2'b00, down_q};
  end

  // Position state: pixel column and row, plus tile column/row and offsets.
  tabf_pkg::front_state_e state_q, state_d;
  logic [CW-1:0] col_q, row_q, tc_q, tr_q, lx_q, ly_q;
  logic          div_start, div_busy_c, div_busy_r;
  logic [CW-1:0] q_col, r_col, q_row, r_row;

  tabf_div u_div_col (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (col_q),
    .divisor_i  (tile_w_q),
    .busy_o     (div_busy_c),
    .quot_o     (q_col),
    .rem_o      (r_col)
  );

  tabf_div u_div_row (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (row_q),
    .divisor_i  (tile_h_q),
    .busy_o     (div_busy_r),
    .quot_o     (q_row),
    .rem_o      (r_row)
  );

  // After a register write the tile position is re-derived before pixels resume.
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    case (state_q)
      tabf_pkg::ST_RUN:   state_d = tabf_pkg::ST_RUN;
      tabf_pkg::ST_START: begin
        div_start = 1'b1;
        state_d   = tabf_pkg::ST_DIV;
      end
      tabf_pkg::ST_DIV: begin
        if (!div_busy_c && !div_busy_r) begin
          state_d = tabf_pkg::ST_RUN;
        end
      end
      default: state_d = tabf_pkg::ST_RUN;
    endcase
    if (cfg_we_i) begin
      state_d = tabf_pkg::ST_START;
    end
  end

  logic accept, div_done;
  assign in_ready_o = (state_q == tabf_pkg::ST_RUN) && !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign div_done   = (state_q == tabf_pkg::ST_DIV) && !div_busy_c && !div_busy_r;

  // Classification of the current pixel.
  logic          last_col, last_row, col_wrap, row_wrap, grid_ok;
  logic [13:0]   idx_full;

  always_comb begin
    last_col = ({1'b0, lx_q} + DW'(1)) == tile_w_q;
    last_row = ({1'b0, ly_q} + DW'(1)) == tile_h_q;
    col_wrap = ({1'b0, col_q} + DW'(1)) >= w_eff;
    row_wrap = ({1'b0, row_q} + DW'(1)) >= h_eff;
    grid_ok  = (tile_w_q != '0) && (tile_h_q != '0) &&
               (across_eff != '0) && (down_eff != '0) &&
               (tc_q < CW'(across_eff)) && (tr_q < CW'(down_eff));
    idx_full = 14'(tr_q[tabf_pkg::MAX_SLOT_BITS-1:0]) * 14'(across_eff) +
               14'(tc_q[tabf_pkg::MAX_SLOT_BITS-1:0]);

    op_o.slot       = tc_q[tabf_pkg::MAX_SLOT_BITS-1:0];
    op_o.painted    = in_alpha_i != '0;
    op_o.first      = (lx_q == '0) && (ly_q == '0);
    op_o.last_col   = last_col;
    op_o.last_row   = last_row;
    op_o.col        = col_q;
    op_o.row        = row_q;
    op_o.emit       = last_col && last_row;
    op_o.tile_index = idx_full[tabf_pkg::INDEX_BITS-1:0];
    op_o.last_tile  = (({1'b0, tr_q} + DW'(1)) == DW'(down_eff)) &&
                      (({1'b0, tc_q} + DW'(1)) == DW'(across_eff));
  end

  // Position update: raster advance on each pixel, reload after division.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tabf_pkg::ST_RUN;
      col_q   <= '0;
      row_q   <= '0;
      tc_q    <= '0;
      tr_q    <= '0;
      lx_q    <= '0;
      ly_q    <= '0;
    end else begin
      state_q <= state_d;
      if (div_done) begin
        tc_q <= q_col;
        lx_q <= r_col;
        tr_q <= q_row;
        ly_q <= r_row;
      end else if (accept) begin
        if (col_wrap) begin
          col_q <= '0;
          lx_q  <= '0;
          tc_q  <= '0;
          if (row_wrap) begin
            row_q <= '0;
            ly_q  <= '0;
            tr_q  <= '0;
          end else begin
            row_q <= row_q + 1'b1;
            if (last_row) begin
              ly_q <= '0;
              tr_q <= tr_q + 1'b1;
            end else begin
              ly_q <= ly_q + 1'b1;
            end
          end
        end else begin
          col_q <= col_q + 1'b1;
          if (last_col) begin
            lx_q <= '0;
            tc_q <= tc_q + 1'b1;
          end else begin
            lx_q <= lx_q + 1'b1;
          end
        end
      end
    end
  end

  assign stat_o.busy = state_q != tabf_pkg::ST_RUN;
  assign stat_o.push = accept && grid_ok;

endmodule
`default_nettype wire

/* hw/rtl/tabf_queue.sv */
// Short queue of classified pixels between front and back.
`default_nettype none
module tabf_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire tabf_pkg::op_t          op_i,
  input  wire logic                   pop_i,
  output      tabf_pkg::op_t          op_o,
  output      tabf_pkg::queue_stat_t  stat_o
);

  localparam int D  = tabf_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(D);

  tabf_pkg::op_t   mem_q [D];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PW:0]     cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = cnt_q == (PW + 1)'(D);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign op_o         = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tabf_back.sv */
// Back part: per-tile-column box tracking and the result output register.
`default_nettype none
module tabf_back #(
  parameter int MAX_TILES_ACROSS = tabf_pkg::DEF_MAX_TILES_ACROSS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  op_valid_i,
  input  wire tabf_pkg::op_t         op_i,
  output      tabf_pkg::back_stat_t  stat_o,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [63:0]           out_data_o,
  output      logic                  out_found_o,
  output      logic                  out_last_o
);

  localparam int CW = tabf_pkg::COORD_BITS;
  localparam int DW = tabf_pkg::DIM_BITS;
  localparam int SW = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
  localparam int NS = MAX_TILES_ACROSS;

  // Tracking slot for each tile column of the current grid row.
  logic          cf_q [NS];
  logic          wd_q [NS];
  logic          hd_q [NS];
  logic [CW-1:0] cx_q [NS];
  logic [CW-1:0] cy_q [NS];
  logic [DW-1:0] rw_q [NS];
  logic [DW-1:0] rh_q [NS];

  logic          cf_d, wd_d, hd_d;
  logic [CW-1:0] cx_d, cy_d;
  logic [DW-1:0] rw_d, rh_d;
  logic [SW-1:0] s;
  logic          pop;

  logic          out_valid_q, out_found_q, out_last_q;
  logic [63:0]   out_data_q;

  assign pop         = op_valid_i && (!out_valid_q || out_ready_i);
  assign stat_o.pop  = pop;
  assign stat_o.emit = op_i.emit;

  // Slot update for one pixel.
  always_comb begin
    s = op_i.slot[SW-1:0];
    if (op_i.first) begin
      cf_d = 1'b0;
      wd_d = 1'b0;
      hd_d = 1'b0;
      cx_d = '0;
      cy_d = '0;
      rw_d = '0;
      rh_d = '0;
    end else begin
      cf_d = cf_q[s];
      wd_d = wd_q[s];
      hd_d = hd_q[s];
      cx_d = cx_q[s];
      cy_d = cy_q[s];
      rw_d = rw_q[s];
      rh_d = rh_q[s];
    end
    if (!cf_d) begin
      if (op_i.painted) begin
        cf_d = 1'b1;
        cx_d = op_i.col;
        cy_d = op_i.row;
        rw_d = DW'(1);
        rh_d = DW'(1);
        wd_d = op_i.last_col;
        hd_d = op_i.last_row;
      end
    end else begin
      // Width run along the corner row.
      if ((op_i.row == cy_d) && !wd_d) begin
        if (op_i.painted) begin
          rw_d = rw_d + 1'b1;
        end
        if (!op_i.painted || op_i.last_col) begin
          wd_d = 1'b1;
        end
      end
      // Height run down the corner column.
      if ((op_i.col == cx_d) && (op_i.row != cy_d) && !hd_d) begin
        if (op_i.painted) begin
          rh_d = rh_d + 1'b1;
        end
        if (!op_i.painted || op_i.last_row) begin
          hd_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) begin
        cf_q[i] <= 1'b0;
        wd_q[i] <= 1'b0;
        hd_q[i] <= 1'b0;
        cx_q[i] <= '0;
        cy_q[i] <= '0;
        rw_q[i] <= '0;
        rh_q[i] <= '0;
      end
    end else if (pop) begin
      cf_q[s] <= cf_d;
      wd_q[s] <= wd_d;
      hd_q[s] <= hd_d;
      cx_q[s] <= cx_d;
      cy_q[s] <= cy_d;
      rw_q[s] <= rw_d;
      rh_q[s] <= rh_d;
    end
  end

  // Result register; box fields read zero for an empty tile.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop && op_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && op_i.emit) begin
      out_found_q <= cf_d;
      out_last_q  <= op_i.last_tile;
      out_data_q  <= {6'b0,
                      cf_d ? rh_d : {DW{1'b0}},
                      cf_d ? rw_d : {DW{1'b0}},
                      cf_d ? cy_d : {CW{1'b0}},
                      cf_d ? cx_d : {CW{1'b0}},
                      op_i.tile_index};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_found_o = out_found_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

/* hw/rtl/tile_alpha_bbox_finder_core.sv */
// A result passes through the queue and then the output register after the tile's last
// pixel beat. Throughput: one pixel beat per cycle while the queue is not full and the
// position is not being re-derived; a four-entry queue decouples front and back. Each
// register write stalls input while two bit-serial dividers re-derive the tile position
// from the current pixel position. Reset (rst_ni low, asynchronous) returns registers to
// defaults, the position to the top-left pixel and all tile slots to empty.
`default_nettype none
`include "assert_macros.svh"
module tile_alpha_bbox_finder_core #(
  parameter int MAX_TILES_ACROSS = tabf_pkg::DEF_MAX_TILES_ACROSS,
  parameter int MAX_TILES_DOWN   = tabf_pkg::DEF_MAX_TILES_DOWN
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration write port.
  input  wire logic                               cfg_we_i,
  input  wire logic [tabf_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [tabf_pkg::DIM_BITS-1:0]      cfg_wdata_i,
  // Pixel stream.
  input  wire logic                               s_axis_tvalid_i,
  output      logic                               s_axis_tready_o,
  input  wire logic [7:0]                         s_axis_tdata_i,  // [7:0] alpha
  // Box stream.
  output      logic                               m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // [7:0] tile_index, [19:8] box_x, [31:20] box_y, [44:32] box_width,
  // [57:45] box_height, [63:58] zero
  output      logic [63:0]                        m_axis_tdata_o,
  output      logic                               m_axis_tuser_o,  // [0] found
  output      logic                               m_axis_tlast_o
);

  tabf_pkg::op_t         fr_op, q_op;
  tabf_pkg::front_stat_t fr_stat;
  tabf_pkg::queue_stat_t q_stat;
  tabf_pkg::back_stat_t  bk_stat;

  // Front: registers, position tracking, classification.
  tabf_front #(
    .MAX_TILES_ACROSS (MAX_TILES_ACROSS),
    .MAX_TILES_DOWN   (MAX_TILES_DOWN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_alpha_i   (s_axis_tdata_i),
    .queue_full_i (q_stat.full),
    .op_o         (fr_op),
    .stat_o       (fr_stat)
  );

  // Queue between front and back.
  tabf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_stat.push),
    .op_i   (fr_op),
    .pop_i  (bk_stat.pop),
    .op_o   (q_op),
    .stat_o (q_stat)
  );

  // Back: box tracking and result register.
  tabf_back #(
    .MAX_TILES_ACROSS (MAX_TILES_ACROSS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (!q_stat.empty),
    .op_i        (q_op),
    .stat_o      (bk_stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_found_o (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

  // The front never pushes into a full queue.
  `TABF_ASSERT_NEVER(a_push_full, clk_i, rst_ni, fr_stat.push && q_stat.full)
  // No pixel is taken while the tile position is being re-derived.
  `TABF_ASSERT(a_busy_stall, clk_i, rst_ni, fr_stat.busy |-> !s_axis_tready_o)
  // A tile's final pixel leaving the queue shows up as a result beat.
  `TABF_ASSERT(a_emit_out, clk_i, rst_ni, bk_stat.pop && bk_stat.emit |=> m_axis_tvalid_o)

endmodule
`default_nettype wire

/* verif/tile_alpha_bbox_finder_checker.sv */
// Checker that predicts each tile box from the pixel beats and compares it with the box stream.
`timescale 1ns / 1ps
module tile_alpha_bbox_finder_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tabf_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [tabf_pkg::DIM_BITS-1:0]     cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  input  logic                              s_axis_tready_i,
  input  logic [7:0]                        s_axis_tdata_i,  // [7:0] alpha
  input  logic                              m_axis_tvalid_i,
  input  logic                              m_axis_tready_i,
  // [7:0] tile_index, [19:8] box_x, [31:20] box_y, [44:32] box_width,
  // [57:45] box_height, [63:58] zero
  input  logic [63:0]                       m_axis_tdata_i,
  input  logic                              m_axis_tuser_i,  // [0] found
  input  logic                              m_axis_tlast_i,
  output int                                boxes_pending_o,
  output int                                mismatches_o
);

  localparam int CW       = tabf_pkg::COORD_BITS;
  localparam int DW       = tabf_pkg::DIM_BITS;
  localparam int IW       = tabf_pkg::INDEX_BITS;
  localparam int MAX_X    = tabf_pkg::DEF_MAX_TILES_ACROSS;
  localparam int MAX_Y    = tabf_pkg::DEF_MAX_TILES_DOWN;

  typedef struct packed {
    logic [IW-1:0] tile_index;
    logic          found;
    logic [CW-1:0] box_x;
    logic [CW-1:0] box_y;
    logic [DW-1:0] box_w;
    logic [DW-1:0] box_h;
    logic          last;
  } tile_box_t;

  tile_box_t expected_boxes[$];

  // Configuration copy.
  logic [DW-1:0]                 image_w, image_h, tile_w, tile_h;
  logic [tabf_pkg::CNT_BITS-1:0] tiles_x, tiles_y;

  // Raster position and per-column tile slots.
  int unsigned col_pos, row_pos;
  bit          corner_seen[MAX_X];
  bit          width_closed[MAX_X];
  bit          height_closed[MAX_X];
  int unsigned corner_col[MAX_X];
  int unsigned corner_row[MAX_X];
  int unsigned span_w[MAX_X];
  int unsigned span_h[MAX_X];
  int          boxes_checked;

  function automatic int unsigned clip_dim(input logic [DW-1:0] v);
    if (v == 0) return 1;
    return (v > tabf_pkg::DIM_LIMIT) ? tabf_pkg::DIM_LIMIT : v;
  endfunction

  task automatic clear_slot(input int unsigned s);
    corner_seen[s]   = 1'b0;
    width_closed[s]  = 1'b0;
    height_closed[s] = 1'b0;
    corner_col[s]    = 0;
    corner_row[s]    = 0;
    span_w[s]        = 0;
    span_h[s]        = 0;
  endtask

  task automatic reset_state();
    image_w = tabf_pkg::RST_IMAGE_WIDTH;
    image_h = tabf_pkg::RST_IMAGE_HEIGHT;
    tile_w  = tabf_pkg::RST_TILE_WIDTH;
    tile_h  = tabf_pkg::RST_TILE_HEIGHT;
    tiles_x = tabf_pkg::RST_TILES_ACROSS;
    tiles_y = tabf_pkg::RST_TILES_DOWN;
    col_pos = 0;
    row_pos = 0;
    for (int s = 0; s < MAX_X; s++) clear_slot(s);
    expected_boxes.delete();
    boxes_checked = 0;
    mismatches_o  = 0;
  endtask

  task automatic store_reg(input logic [tabf_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [DW-1:0] data);
    case (idx)
      tabf_pkg::REG_IMAGE_WIDTH:  image_w = data;
      tabf_pkg::REG_IMAGE_HEIGHT: image_h = data;
      tabf_pkg::REG_TILE_WIDTH:   tile_w  = data;
      tabf_pkg::REG_TILE_HEIGHT:  tile_h  = data;
      tabf_pkg::REG_TILES_ACROSS: tiles_x = data[tabf_pkg::CNT_BITS-1:0];
      tabf_pkg::REG_TILES_DOWN:   tiles_y = data[tabf_pkg::CNT_BITS-1:0];
      default: ;
    endcase
  endtask

  // Advance the raster position by one pixel and update the slot of its tile.
  task automatic track_pixel(input logic [7:0] alpha);
    bit          painted, at_right, at_bottom;
    int unsigned c, r, tw, th, across, down, tc, tr, lx, ly;
    tile_box_t   box;
    painted = (alpha != 8'd0);
    c       = col_pos;
    r       = row_pos;
    tw      = tile_w;
    th      = tile_h;
    across  = (tiles_x > MAX_X) ? MAX_X : tiles_x;
    down    = (tiles_y > MAX_Y) ? MAX_Y : tiles_y;

    if (col_pos + 1 >= clip_dim(image_w)) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= clip_dim(image_h)) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end

    // No grid at all, or a pixel outside it.
    if (tw == 0 || th == 0 || across == 0 || down == 0) return;
    tc = c / tw;
    tr = r / th;
    if (tc >= across || tr >= down) return;
    lx        = c - tc * tw;
    ly        = r - tr * th;
    at_right  = (lx + 1 == tw);
    at_bottom = (ly + 1 == th);

    if (lx == 0 && ly == 0) clear_slot(tc);

    if (!corner_seen[tc]) begin
      if (painted) begin
        corner_seen[tc]   = 1'b1;
        corner_col[tc]    = c;
        corner_row[tc]    = r;
        span_w[tc]        = 1;
        span_h[tc]        = 1;
        width_closed[tc]  = at_right;
        height_closed[tc] = at_bottom;
      end
    end else begin
      if (r == corner_row[tc] && !width_closed[tc]) begin
        if (painted) span_w[tc]++;
        if (!painted || at_right) width_closed[tc] = 1'b1;
      end
      if (c == corner_col[tc] && r != corner_row[tc] && !height_closed[tc]) begin
        if (painted) span_h[tc]++;
        if (!painted || at_bottom) height_closed[tc] = 1'b1;
      end
    end

    // The bottom-right pixel of a tile closes its box.
    if (at_right && at_bottom) begin
      box.tile_index = IW'(tr * across + tc);
      box.found      = corner_seen[tc];
      box.box_x      = box.found ? CW'(corner_col[tc]) : '0;
      box.box_y      = box.found ? CW'(corner_row[tc]) : '0;
      box.box_w      = box.found ? DW'(span_w[tc]) : '0;
      box.box_h      = box.found ? DW'(span_h[tc]) : '0;
      box.last       = (tr + 1 == down) && (tc + 1 == across);
      expected_boxes.push_back(box);
    end
  endtask

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] box %0d %s: got %0d, expected %0d", $time, boxes_checked, what, got, want);
    mismatches_o++;
  endtask

  task automatic check_box();
    tile_box_t seen, want;
    seen.tile_index = m_axis_tdata_i[7:0];
    seen.box_x      = m_axis_tdata_i[19:8];
    seen.box_y      = m_axis_tdata_i[31:20];
    seen.box_w      = m_axis_tdata_i[44:32];
    seen.box_h      = m_axis_tdata_i[57:45];
    seen.found      = m_axis_tuser_i;
    seen.last       = m_axis_tlast_i;
    if (expected_boxes.size() == 0) begin
      note_mismatch("unexpected box, tile_index", seen.tile_index, -1);
      boxes_checked++;
      return;
    end
    want = expected_boxes.pop_front();
    if (seen.tile_index != want.tile_index) note_mismatch("tile_index", seen.tile_index, want.tile_index);
    if (seen.found != want.found) note_mismatch("found", seen.found, want.found);
    if (seen.box_x != want.box_x) note_mismatch("box_x", seen.box_x, want.box_x);
    if (seen.box_y != want.box_y) note_mismatch("box_y", seen.box_y, want.box_y);
    if (seen.box_w != want.box_w) note_mismatch("box_width", seen.box_w, want.box_w);
    if (seen.box_h != want.box_h) note_mismatch("box_height", seen.box_h, want.box_h);
    if (seen.last != want.last) note_mismatch("last", seen.last, want.last);
    if (m_axis_tdata_i[63:58] != '0) note_mismatch("tdata padding", m_axis_tdata_i[63:58], 0);
    boxes_checked++;
  endtask

  // Watch every channel at the rising edge; predictions are queued before any compare.
  // A pixel taken at the same edge as a register write still sees the old setting.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_state();
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) track_pixel(s_axis_tdata_i);
      if (cfg_we_i) store_reg(cfg_idx_i, cfg_wdata_i);
      if (m_axis_tvalid_i && m_axis_tready_i) check_box();
    end
    boxes_pending_o = expected_boxes.size();
  end

endmodule

/* verif/tile_alpha_bbox_finder_core_tb.sv */
// Testbench top for the tile alpha bounding-box finder: drives pixels and settings, gives the verdict.
`timescale 1ns / 1ps
module tile_alpha_bbox_finder_core_tb;

  localparam int MAX_GAP         = 18;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 16;
  localparam int RANDOM_PIXELS   = 950;

  // Hand-made 7 x 3 image for a 3 x 1 grid of 2 x 2 tiles; column 6 and row 2 lie
  // outside the grid. The first tile's corner sits in its last column, the second
  // tile's corner in its last row, and the third tile stays empty.
  localparam logic [0:20][7:0] SAMPLE_IMAGE = {
    8'd0,   8'd255, 8'd0, 8'd0,  8'd0, 8'd0, 8'd9,
    8'd128, 8'd200, 8'd1, 8'd77, 8'd0, 8'd0, 8'd0,
    8'd3,   8'd3,   8'd3, 8'd3,  8'd3, 8'd3, 8'd3
  };

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                              cfg_we    = 1'b0;
  logic [tabf_pkg::CFG_IDX_BITS-1:0] cfg_idx   = tabf_pkg::REG_IMAGE_WIDTH;
  logic [tabf_pkg::DIM_BITS-1:0]     cfg_wdata = '0;
  logic                              s_tvalid  = 1'b0;
  logic                              s_tready;
  logic [7:0]                        s_tdata   = 8'd0;
  logic                              m_tvalid;
  logic                              m_tready  = 1'b0;
  logic [63:0]                       m_tdata;
  logic                              m_tuser;
  logic                              m_tlast;

  int boxes_pending;
  int mismatches;

  bit src_idle_on      = 1'b1;
  bit sink_idle_on     = 1'b1;
  bit hold_off_request = 1'b0;

  always #5 clk_i = ~clk_i;

  tile_alpha_bbox_finder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  tile_alpha_bbox_finder_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .boxes_pending_o (boxes_pending),
    .mismatches_o    (mismatches)
  );

  function automatic logic [7:0] draw_alpha(input int density);
    if ($urandom_range(0, 99) >= density) return 8'd0;
    case ($urandom_range(0, 7))
      0:       return 8'hFF;
      1:       return 8'h01;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Wait until every box has come back, then let pixels without a box drain.
  task automatic settle();
    while (boxes_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [tabf_pkg::CFG_IDX_BITS-1:0] idx,
                           input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value[tabf_pkg::DIM_BITS-1:0];
    @(negedge clk_i);
  endtask

  // Write all six registers on consecutive cycles.
  task automatic program_grid(input int unsigned iw, ih, tw, th, ta, td);
    cfg_write(tabf_pkg::REG_IMAGE_WIDTH, iw);
    cfg_write(tabf_pkg::REG_IMAGE_HEIGHT, ih);
    cfg_write(tabf_pkg::REG_TILE_WIDTH, tw);
    cfg_write(tabf_pkg::REG_TILE_HEIGHT, th);
    cfg_write(tabf_pkg::REG_TILES_ACROSS, ta);
    cfg_write(tabf_pkg::REG_TILES_DOWN, td);
    cfg_we <= 1'b0;
  endtask

  // Offer one pixel beat, after a random gap if source idling is on, and wait for it to be taken.
  task automatic send_pixel(input logic [7:0] alpha);
    int gap;
    gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= alpha;
    do @(posedge clk_i); while (!(s_tvalid && s_tready));
    @(negedge clk_i);
  endtask

  task automatic send_pixels(input int count, input int density);
    repeat (count) send_pixel(draw_alpha(density));
    s_tvalid <= 1'b0;
  endtask

  // Box sink: random stalls per beat, and one long hold-off on request.
  initial begin : box_sink
    int pause;
    @(posedge rst_n);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 29) == 0) sink_idle_on = !sink_idle_on;
      pause = sink_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_off_request) begin
        pause            = HOLD_OFF_CYCLES;
        hold_off_request = 1'b0;
      end
      if (pause > 0) begin
        m_tready <= 1'b0;
        repeat (pause) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_tvalid && m_tready));
    end
  end

  initial begin : stimulus
    int          random_pixels;
    int          density;
    int          count;
    int unsigned iw, ih, tw, th, ta, td;
    random_pixels = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Directed frame: alpha extremes, corners on tile edges, an empty tile.
    program_grid(7, 3, 2, 2, 3, 1);
    for (int i = 0; i < 21; i++) send_pixel(SAMPLE_IMAGE[i]);
    s_tvalid <= 1'b0;

    // Corner settings with random content.
    settle();
    program_grid(4096, 4096, 1, 1, 16, 16);    // largest image, one-pixel tiles
    send_pixels(18, 70);
    settle();
    program_grid(8191, 0, 3, 1, 31, 31);       // oversized image and tile counts
    send_pixels(12, 70);
    settle();
    program_grid(5, 4, 0, 2, 2, 2);            // zero tile width; position wraps
    send_pixels(6, 50);
    settle();
    program_grid(5, 4, 4096, 4096, 1, 1);      // grid larger than the image
    send_pixels(20, 50);
    settle();
    program_grid(6, 2, 2, 1, 0, 3);            // zero tiles across
    send_pixels(6, 50);
    settle();
    program_grid(1, 1, 1, 1, 1, 1);            // one-pixel image
    send_pixels(6, 50);

    // Full 16 x 16 grid of one-pixel tiles under a long receiver hold-off.
    settle();
    program_grid(16, 16, 1, 1, 16, 16);
    src_idle_on      = 1'b0;
    hold_off_request = 1'b1;
    send_pixels(256, 60);
    random_pixels += 256;

    // Random grids, mostly fitting the image, one or two frames each.
    while (random_pixels < RANDOM_PIXELS) begin
      settle();
      tw = $urandom_range(1, 5);
      th = $urandom_range(1, 4);
      ta = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
      td = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 3);
      iw = tw * ((ta > 4) ? 4 : ta) + $urandom_range(0, 3);
      ih = th * ((td > 3) ? 3 : td) + $urandom_range(0, 2);
      if ($urandom_range(0, 5) == 0) iw = $urandom_range(1, iw + 1);
      if ($urandom_range(0, 5) == 0) ih = $urandom_range(1, ih + 1);
      program_grid(iw, ih, tw, th, ta, td);
      case ($urandom_range(0, 4))
        0:       density = 0;
        1:       density = 35;
        2:       density = 70;
        3:       density = 90;
        default: density = 100;
      endcase
      src_idle_on = ($urandom_range(0, 3) != 0);
      count = ((iw == 0) ? 1 : iw) * ((ih == 0) ? 1 : ih) * $urandom_range(1, 2)
              + $urandom_range(0, 4);
      // Keep the total pixel count near the planned amount.
      if (count > RANDOM_PIXELS - random_pixels) count = RANDOM_PIXELS - random_pixels;
      send_pixels(count, density);
      random_pixels += count;
    end

    settle();
    if (mismatches == 0 && boxes_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
